@@ src/pfri_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and fixed constants of the prime-field reduce and invert block.
package pfri_pkg;

	localparam int OPERAND_W = 32;

	typedef enum logic {
		KIND_REDUCE = 1'b0,
		KIND_INVERT = 1'b1
	} kind_t;

endpackage

@@ src/prime_field_reduce_and_invert.sv @@
`timescale 1ns / 1ps
// Top level: pipelined reduction mod p and field inversion by a fixed power ladder.
//
// Input stream (s_*): one transfer carries a 32-bit operand in s_tdata and the kind
// in s_tuser: KIND_REDUCE returns operand mod MODULUS, KIND_INVERT returns
// operand^(MODULUS-2) mod MODULUS, which is the field inverse, and 0 for zero.
// Output stream (m_*): one transfer per input transfer, in the same order, the
// result in the low FIELD_BITS bits of m_tdata, zero padding above.
// Pipeline: the first reduction takes three stages; each of the
// EB exponent bits, EB being the bit count of MODULUS-2, then takes one multiply
// stage plus a three-stage reciprocal reduction, with the squaring and the
// accumulate running side by side. One more stage is the output register.
// Throughput: one transfer per cycle per side while m_tready is high; kinds mix freely.
// Stall: when the receiver holds m_tready low, a skid register catches the one
// result still leaving the pipeline, then s_tready drops and the whole pipeline
// holds until the waiting result is taken. Nothing is lost or repeated.
// Reset: arst_n clears all valid bits, those of the output and skid registers too, at
// once; the data registers are not reset, and the block is ready as soon as reset ends.
module prime_field_reduce_and_invert #(
	parameter int MODULUS = 4093,
	parameter int FIELD_BITS = 12,
	localparam int OW = ((FIELD_BITS + 7) / 8) * 8
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  pfri_pkg::kind_t                s_tuser,   // kind
	input  logic [pfri_pkg::OPERAND_W-1:0] s_tdata,   // operand
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [OW-1:0]                  m_tdata    // result, zero padding
);
	import pfri_pkg::*;

	localparam int MW = $clog2(MODULUS + 1);     // field element width
	localparam int EB = $clog2(MODULUS - 1);     // bits in the exponent MODULUS-2
	localparam logic [EB-1:0] EXP = EB'(MODULUS - 2);
	localparam int RED_LAT  = 3;
	localparam int STEP_LAT = 4;
	localparam int KEEP_LEN = STEP_LAT * EB;
	localparam int D = RED_LAT + KEEP_LEN;       // pipeline depth before the output register

	logic en;                                    // advance the whole pipeline
	logic [D:1] vld_s;
	logic [D:1] inv_s;
	logic [MW-1:0] keep_s [1:KEEP_LEN];          // plain remainder, carried alongside
	logic [MW-1:0] base_w [0:EB-1];
	logic [MW-1:0] acc_w  [0:EB];
	logic [MW-1:0] res;
	logic [FIELD_BITS-1:0] res_fb;

	logic                  out_valid_q;
	logic                  skid_valid_q;
	logic [FIELD_BITS-1:0] out_q;
	logic [FIELD_BITS-1:0] skid_q;

	// Hold the pipeline only while the skid register is occupied.
	assign en       = !skid_valid_q;
	assign s_tready = en;

	// Valid bits and kind travel with the data.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[D-1:1], s_tvalid};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			inv_s <= {inv_s[D-1:1], s_tuser == KIND_INVERT};
		end
	end

	// Reduce the operand first; both kinds need it.
	pfri_modred #(.MODULUS(MODULUS)) u_red0 (
		.clk (clk),
		.en  (en),
		.x   (s_tdata),
		.r   (base_w[0])
	);

	always_ff @(posedge clk) begin
		if (en) begin
			keep_s[1] <= base_w[0];
			for (int k = 2; k <= KEEP_LEN; k++) begin
				keep_s[k] <= keep_s[k-1];
			end
		end
	end

	assign acc_w[0] = MW'(1);

	// One exponent bit per step, least significant first.
	for (genvar i = 0; i < EB; i++) begin : g_step
		logic [MW-1:0]        factor;
		logic [OPERAND_W-1:0] mul_s1;

		// Multiply by the base where the exponent bit is set, by one elsewhere.
		assign factor = EXP[i] ? base_w[i] : MW'(1);

		always_ff @(posedge clk) begin
			if (en) begin
				mul_s1 <= OPERAND_W'(acc_w[i]) * OPERAND_W'(factor);
			end
		end

		pfri_modred #(.MODULUS(MODULUS)) u_mul (
			.clk (clk),
			.en  (en),
			.x   (mul_s1),
			.r   (acc_w[i+1])
		);

		// The last step needs no further square of the base.
		if (i < EB - 1) begin : g_sq
			logic [OPERAND_W-1:0] sq_s1;

			always_ff @(posedge clk) begin
				if (en) begin
					sq_s1 <= OPERAND_W'(base_w[i]) * OPERAND_W'(base_w[i]);
				end
			end

			pfri_modred #(.MODULUS(MODULUS)) u_sq (
				.clk (clk),
				.en  (en),
				.x   (sq_s1),
				.r   (base_w[i+1])
			);
		end
	end

	assign res    = inv_s[D] ? acc_w[EB] : keep_s[KEEP_LEN];
	assign res_fb = FIELD_BITS'(res);

	// Output register plus one skid entry.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (skid_valid_q) begin
					skid_valid_q <= 1'b0;
				end else begin
					out_valid_q <= vld_s[D];
				end
			end else if (!out_valid_q) begin
				out_valid_q <= vld_s[D];
			end else if (vld_s[D]) begin
				// Output waits; catch the result leaving the pipeline.
				skid_valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (m_tvalid && m_tready) begin
			out_q <= skid_valid_q ? skid_q : res_fb;
		end else if (!out_valid_q) begin
			out_q <= res_fb;
		end else if (en) begin
			skid_q <= res_fb;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = OW'(out_q);

endmodule

@@ src/pfri_modred.sv @@
`timescale 1ns / 1ps
// Three-stage reduction of a 32-bit value modulo a constant prime, by reciprocal multiply.
module pfri_modred #(
	parameter int MODULUS = 4093,
	localparam int MW = $clog2(MODULUS + 1)
) (
	input  logic                           clk,
	input  logic                           en,
	input  logic [pfri_pkg::OPERAND_W-1:0] x,
	output logic [MW-1:0]                  r
);
	import pfri_pkg::*;

	// The remainder estimate lands in [0, 2*MODULUS), one bit wider than the field.
	localparam int RW = MW + 1;
	localparam logic [OPERAND_W-1:0] MU =
		OPERAND_W'((64'd1 << OPERAND_W) / 64'(MODULUS));
	localparam logic [RW-1:0] M_R = RW'(MODULUS);

	logic [2*OPERAND_W-1:0] prod;
	logic [RW-1:0]          x_s1;
	logic [RW-1:0]          q_s1;
	logic [RW-1:0]          r0_s2;
	logic [MW-1:0]          r_s3;

	assign prod = (2*OPERAND_W)'(x) * (2*OPERAND_W)'(MU);

	// Only the low bits of x - q*M matter, since the true difference is below 2*M.
	always_ff @(posedge clk) begin
		if (en) begin
			x_s1  <= x[RW-1:0];
			q_s1  <= prod[OPERAND_W +: RW];
			r0_s2 <= x_s1 - RW'(q_s1 * M_R);
			r_s3  <= (r0_s2 >= M_R) ? MW'(r0_s2 - M_R) : MW'(r0_s2);
		end
	end

	assign r = r_s3;

endmodule

@@ src/pfri_check.sv @@
`timescale 1ns / 1ps
// Port-level checker for the prime-field reduce and invert block, with its bind.
module pfri_check #(
	parameter int MODULUS = 4093,
	parameter int FIELD_BITS = 12,
	localparam int OW = ((FIELD_BITS + 7) / 8) * 8
) (
	input logic          clk,
	input logic          arst_n,
	input logic          s_tready,
	input logic          m_tvalid,
	input logic          m_tready,
	input logic [OW-1:0] m_tdata
);
	import pfri_pkg::*;

	// A stalled result holds.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed or dropped while stalled");

	// Every result is a field element.
	a_in_field: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (32'(m_tdata[FIELD_BITS-1:0]) < 32'(MODULUS)))
		else $error("result not reduced below the modulus");

	// Input backpressure only while a result is waiting.
	a_ready_wait: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> m_tvalid)
		else $error("input held off with no result pending");

	// The skid fills, and s_tready falls, only on an output stall.
	a_ready_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(s_tready) |-> $past(m_tvalid && !m_tready))
		else $error("input held off without an output stall");

endmodule

bind prime_field_reduce_and_invert pfri_check #(
	.MODULUS    (MODULUS),
	.FIELD_BITS (FIELD_BITS)
) u_pfri_check (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
